[rtl/core/mwsm_pkg.sv]
// Package for the mecanum wheel speed mixer: widths, register indexes and
// the payload structs that pass between the front pipeline and the normalizer.
// No dependencies.
package mwsm_pkg;

   localparam int WHEELS     = 4;
   localparam int CMD_W      = 16;   // Q4.12 command fields
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int SUM_W      = 18;   // wheel sums, Q.12
   localparam int SPEED_W    = 34;   // wheel speeds, Q.20, signed
   localparam int MAG_W      = 33;   // wheel speed magnitude
   localparam int DUTY_W     = 16;
   localparam int DIV_STEPS  = 16;   // one quotient bit per step

   localparam logic [CSR_DATA_W-1:0] RADIUS_RESET = 16'd5120;
   localparam logic [CSR_DATA_W-1:0] BASE_RESET   = 16'd15729;
   localparam logic [MAG_W-1:0]      ONE_Q20      = 33'd1 << 20;
   localparam logic [DUTY_W-1:0]     FULL_DUTY    = 16'd32768;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_RADIUS = 8'd0,
      CSR_HALF_BASE  = 8'd1
   } csr_index_type;

   // Magnitudes, peak and signs handed to the normalizer
   typedef struct packed {
      logic [WHEELS-1:0][MAG_W-1:0] mag;
      logic [MAG_W-1:0]             peak;
      logic [WHEELS-1:0]            forward;
   } norm_in_type;

   // One lane of the restoring divider
   typedef struct packed {
      logic [MAG_W-1:0]  rem;
      logic [DUTY_W-1:0] nq;          // numerator bits out, quotient bits in
      logic [DUTY_W-1:0] small_duty;
      logic              forward;
   } lane_type;

   typedef struct packed {
      lane_type [WHEELS-1:0] lane;
      logic [MAG_W-1:0]      divisor;
      logic                  scale;
   } div_stage_type;

   typedef struct packed {
      logic [WHEELS-1:0][DUTY_W-1:0] duty;
      logic [WHEELS-1:0]             forward;
   } result_type;

endpackage

[rtl/core/mwsm_channels.sv]
// Channel interfaces of the mecanum wheel speed mixer: request, response and
// register write. Depends on mwsm_pkg for widths.
interface mwsm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [mwsm_pkg::CMD_W-1:0]   speed_x;
   logic signed [mwsm_pkg::CMD_W-1:0]   speed_y;
   logic signed [mwsm_pkg::CMD_W-1:0]   turn_rate;

   modport source (output valid, speed_x, speed_y, turn_rate, input ready);
   modport sink   (input valid, speed_x, speed_y, turn_rate, output ready);
endinterface

interface mwsm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mwsm_pkg::DUTY_W-1:0]   wheel0_duty;
   logic                          wheel0_forward;
   logic [mwsm_pkg::DUTY_W-1:0]   wheel1_duty;
   logic                          wheel1_forward;
   logic [mwsm_pkg::DUTY_W-1:0]   wheel2_duty;
   logic                          wheel2_forward;
   logic [mwsm_pkg::DUTY_W-1:0]   wheel3_duty;
   logic                          wheel3_forward;

   modport source (output valid, wheel0_duty, wheel0_forward, wheel1_duty, wheel1_forward,
                   wheel2_duty, wheel2_forward, wheel3_duty, wheel3_forward,
                   input ready);
   modport sink   (input valid, wheel0_duty, wheel0_forward, wheel1_duty, wheel1_forward,
                   wheel2_duty, wheel2_forward, wheel3_duty, wheel3_forward,
                   output ready);
endinterface

interface mwsm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mwsm_pkg::CSR_IDX_W-1:0]    index;
   logic [mwsm_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/mecanum_wheel_speed_mixer_core.sv]
// Top level of the mecanum wheel speed mixer: register file, kinematics
// front pipeline and the normalizer. Depends on mwsm_pkg, mwsm_channels and
// mwsm_normalizer.
//
//  channel  direction  moves                               handshake
//  req_if   in         speed_x, speed_y, turn_rate (Q4.12)   valid/ready
//  rsp_if   out        four duty (Q1.15) + forward bits      valid/ready
//  csr_if   in         register index, 16-bit data           valid/ready
//
// One request enters per cycle unless a stall holds the first stage; from
// acceptance to response each passes six front stages, numerator setup, one
// divider step per quotient bit (16) and the output register. Reset (synchronous)
// empties the pipeline and reloads the two registers. Each stage holds while
// the next is full and stalled, so bubbles close up; a stalled response holds
// off the request side only once every stage is full.
module mecanum_wheel_speed_mixer_core (
   input  logic       clock,
   input  logic       reset,
   mwsm_req_if.sink   req_if,
   mwsm_rsp_if.source rsp_if,
   mwsm_csr_if.sink   csr_if
);

   localparam int W = mwsm_pkg::WHEELS;

   // Configuration registers
   logic [mwsm_pkg::CSR_DATA_W-1:0] radius_ff;
   logic [mwsm_pkg::CSR_DATA_W-1:0] base_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= mwsm_pkg::RADIUS_RESET;
         base_ff   <= mwsm_pkg::BASE_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            mwsm_pkg::CSR_INV_RADIUS: radius_ff <= csr_if.data;
            mwsm_pkg::CSR_HALF_BASE:  base_ff   <= csr_if.data;
            default: ;
         endcase
      end
   end

   // Stage valids and stall chain
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff, e_v_ff, f_v_ff;
   logic a_en, b_en, c_en, d_en, e_en, f_en;
   logic norm_ready;

   assign f_en = !f_v_ff || norm_ready;
   assign e_en = !e_v_ff || f_en;
   assign d_en = !d_v_ff || e_en;
   assign c_en = !c_v_ff || d_en;
   assign b_en = !b_v_ff || c_en;
   assign a_en = !a_v_ff || b_en;
   assign req_if.ready = a_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
      end else begin
         if (a_en) a_v_ff <= req_if.valid;
         if (b_en) b_v_ff <= a_v_ff;
         if (c_en) c_v_ff <= b_v_ff;
         if (d_en) d_v_ff <= c_v_ff;
         if (e_en) e_v_ff <= d_v_ff;
         if (f_en) f_v_ff <= e_v_ff;
      end
   end

   // Stage A: rotation product turn_rate * half_base_sum (Q.28)
   logic signed [mwsm_pkg::CMD_W-1:0] a_vx_ff, a_vy_ff;
   logic signed [31:0]                a_prod_ff;
   logic signed [32:0]                a_prod;

   assign a_prod = req_if.turn_rate * $signed({1'b0, base_ff});

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_vx_ff   <= req_if.speed_x;
         a_vy_ff   <= req_if.speed_y;
         a_prod_ff <= a_prod[31:0];
      end
   end

   // Stage B: round rotation term to Q.12, form the four wheel sums
   logic signed [31:0]                b_bias;
   logic signed [mwsm_pkg::SUM_W-1:0] b_vx, b_vy, b_turn;
   logic signed [mwsm_pkg::SUM_W-1:0] b_sum_ff [W];

   assign b_bias = a_prod_ff + 32'sd32768;
   assign b_turn = {{2{b_bias[31]}}, b_bias[31:16]};
   assign b_vx   = {{2{a_vx_ff[15]}}, a_vx_ff};
   assign b_vy   = {{2{a_vy_ff[15]}}, a_vy_ff};

   always_ff @(posedge clock) begin
      if (b_en) begin
         b_sum_ff[0] <= b_vx - b_vy - b_turn;
         b_sum_ff[1] <= b_vx + b_vy + b_turn;
         b_sum_ff[2] <= b_vx + b_vy - b_turn;
         b_sum_ff[3] <= b_vx - b_vy + b_turn;
      end
   end

   // Stage C: wheel speeds in Q.20, one multiplier per wheel
   logic signed [mwsm_pkg::SPEED_W:0]   c_prod [W];
   logic signed [mwsm_pkg::SPEED_W-1:0] c_w_ff [W];

   always_comb begin
      for (int i = 0; i < W; i++) begin
         c_prod[i] = b_sum_ff[i] * $signed({1'b0, radius_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (c_en) begin
         for (int i = 0; i < W; i++) c_w_ff[i] <= c_prod[i][mwsm_pkg::SPEED_W-1:0];
      end
   end

   // Stage D: magnitudes and direction bits
   logic [mwsm_pkg::SPEED_W-1:0] d_neg [W];
   logic [mwsm_pkg::MAG_W-1:0]   d_mag_ff [W];
   logic [W-1:0]                 d_fwd_ff;

   always_comb begin
      for (int i = 0; i < W; i++) d_neg[i] = -c_w_ff[i];
   end

   always_ff @(posedge clock) begin
      if (d_en) begin
         for (int i = 0; i < W; i++) begin
            d_mag_ff[i] <= c_w_ff[i][mwsm_pkg::SPEED_W-1] ? d_neg[i][mwsm_pkg::MAG_W-1:0]
                                                          : c_w_ff[i][mwsm_pkg::MAG_W-1:0];
            d_fwd_ff[i] <= !c_w_ff[i][mwsm_pkg::SPEED_W-1];
         end
      end
   end

   // Stage E: pairwise maxima
   logic [mwsm_pkg::MAG_W-1:0] e_mag_ff [W];
   logic [mwsm_pkg::MAG_W-1:0] e_max01_ff, e_max23_ff;
   logic [W-1:0]               e_fwd_ff;

   always_ff @(posedge clock) begin
      if (e_en) begin
         for (int i = 0; i < W; i++) e_mag_ff[i] <= d_mag_ff[i];
         e_fwd_ff   <= d_fwd_ff;
         e_max01_ff <= (d_mag_ff[0] > d_mag_ff[1]) ? d_mag_ff[0] : d_mag_ff[1];
         e_max23_ff <= (d_mag_ff[2] > d_mag_ff[3]) ? d_mag_ff[2] : d_mag_ff[3];
      end
   end

   // Stage F: overall peak magnitude
   mwsm_pkg::norm_in_type f_ff;

   always_ff @(posedge clock) begin
      if (f_en) begin
         for (int i = 0; i < W; i++) f_ff.mag[i] <= e_mag_ff[i];
         f_ff.forward <= e_fwd_ff;
         f_ff.peak    <= (e_max01_ff > e_max23_ff) ? e_max01_ff : e_max23_ff;
      end
   end

   // Normalizer and response
   mwsm_pkg::result_type rsp_data;

   mwsm_normalizer u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_v_ff),
      .in_ready  (norm_ready),
      .in_data   (f_ff),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_data)
   );

   assign rsp_if.wheel0_duty    = rsp_data.duty[0];
   assign rsp_if.wheel0_forward = rsp_data.forward[0];
   assign rsp_if.wheel1_duty    = rsp_data.duty[1];
   assign rsp_if.wheel1_forward = rsp_data.forward[1];
   assign rsp_if.wheel2_duty    = rsp_data.duty[2];
   assign rsp_if.wheel2_forward = rsp_data.forward[2];
   assign rsp_if.wheel3_duty    = rsp_data.duty[3];
   assign rsp_if.wheel3_forward = rsp_data.forward[3];

   // Peak bounds every wheel magnitude
   a_peak_max: assert property (@(posedge clock) disable iff (reset)
      f_v_ff |-> f_ff.mag[0] <= f_ff.peak && f_ff.mag[1] <= f_ff.peak &&
                 f_ff.mag[2] <= f_ff.peak && f_ff.mag[3] <= f_ff.peak)
      else $error("peak below a wheel magnitude");

   // A reverse wheel always has a nonzero magnitude
   a_reverse_mag: assert property (@(posedge clock) disable iff (reset)
      d_v_ff |-> (d_fwd_ff[0] || d_mag_ff[0] != '0) && (d_fwd_ff[1] || d_mag_ff[1] != '0) &&
                 (d_fwd_ff[2] || d_mag_ff[2] != '0) && (d_fwd_ff[3] || d_mag_ff[3] != '0))
      else $error("reverse direction with zero speed");

   // Reset reloads both registers
   a_csr_reset: assert property (@(posedge clock)
      reset |=> radius_ff == mwsm_pkg::RADIUS_RESET && base_ff == mwsm_pkg::BASE_RESET)
      else $error("registers not at reset value");

endmodule

[rtl/core/mwsm_normalizer.sv]
// Normalizer of the wheel speed mixer: numerator setup, a 16-step pipelined
// restoring divider per wheel, duty select and output register.
// Depends on mwsm_pkg.
module mwsm_normalizer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mwsm_pkg::norm_in_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mwsm_pkg::result_type  out_data
);

   localparam int STEPS = mwsm_pkg::DIV_STEPS;

   // One restoring step: shift a numerator bit in, subtract when it fits
   function automatic mwsm_pkg::lane_type div_step(input mwsm_pkg::lane_type cur,
                                                   input logic [mwsm_pkg::MAG_W-1:0] divisor);
      logic [mwsm_pkg::MAG_W:0] trial;
      logic [mwsm_pkg::MAG_W:0] diff;
      mwsm_pkg::lane_type       nxt;
      nxt   = cur;
      trial = {cur.rem, cur.nq[mwsm_pkg::DUTY_W-1]};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
         nxt.rem = diff[mwsm_pkg::MAG_W-1:0];
         nxt.nq  = {cur.nq[mwsm_pkg::DUTY_W-2:0], 1'b1};
      end else begin
         nxt.rem = trial[mwsm_pkg::MAG_W-1:0];
         nxt.nq  = {cur.nq[mwsm_pkg::DUTY_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // stage 0 is numerator setup, stages 1..STEPS are divider steps
   mwsm_pkg::div_stage_type stg_ff [STEPS+1];
   mwsm_pkg::div_stage_type stg_in [STEPS+1];
   logic [STEPS:0]          vld_ff;
   logic [STEPS:0]          stg_en;
   logic                    out_en;
   logic                    out_v_ff;
   mwsm_pkg::result_type    out_ff;
   mwsm_pkg::result_type    out_in;

   // Stall chain: a stage moves when it is empty or the next one moves
   assign out_en = !out_v_ff || out_ready;
   always_comb begin
      stg_en[STEPS] = !vld_ff[STEPS] || out_en;
      for (int s = STEPS - 1; s >= 0; s--) begin
         stg_en[s] = !vld_ff[s] || stg_en[s+1];
      end
   end
   assign in_ready = stg_en[0];

   // Numerator a*32768 + peak/2, split into initial remainder and low bits
   always_comb begin
      logic [mwsm_pkg::MAG_W+15:0] num;
      logic [mwsm_pkg::MAG_W:0]    rnd;
      stg_in[0].divisor = in_data.peak;
      stg_in[0].scale   = in_data.peak > mwsm_pkg::ONE_Q20;
      for (int i = 0; i < mwsm_pkg::WHEELS; i++) begin
         num = {in_data.mag[i], 15'd0}
             + {16'd0, in_data.peak[mwsm_pkg::MAG_W-1:1]};
         rnd = {1'b0, in_data.mag[i]} + 34'd16;
         stg_in[0].lane[i].rem        = num[mwsm_pkg::MAG_W+15:16];
         stg_in[0].lane[i].nq         = num[15:0];
         stg_in[0].lane[i].small_duty = rnd[20:5];
         stg_in[0].lane[i].forward    = in_data.forward[i];
      end
      for (int s = 1; s <= STEPS; s++) begin
         stg_in[s] = stg_ff[s-1];
         for (int i = 0; i < mwsm_pkg::WHEELS; i++) begin
            stg_in[s].lane[i] = div_step(stg_ff[s-1].lane[i], stg_ff[s-1].divisor);
         end
      end
   end

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stg_en[0]) vld_ff[0] <= in_valid;
         for (int s = 1; s <= STEPS; s++) begin
            if (stg_en[s]) vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      for (int s = 0; s <= STEPS; s++) begin
         if (stg_en[s]) stg_ff[s] <= stg_in[s];
      end
   end

   // Duty select: quotient when scaling, rounded shift otherwise
   always_comb begin
      for (int i = 0; i < mwsm_pkg::WHEELS; i++) begin
         out_in.duty[i]    = stg_ff[STEPS].scale ? stg_ff[STEPS].lane[i].nq
                                                 : stg_ff[STEPS].lane[i].small_duty;
         out_in.forward[i] = stg_ff[STEPS].lane[i].forward;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_en) begin
         out_v_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) out_ff <= out_in;
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

   // Scaling always starts with a nonzero divisor
   a_scale_divisor: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && stg_ff[0].scale |-> stg_ff[0].divisor != '0)
      else $error("scaling with zero divisor");

   // Remainder of lanes 0 and 3 stays below the divisor after the last step
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STEPS] && stg_ff[STEPS].scale |->
      stg_ff[STEPS].lane[0].rem < stg_ff[STEPS].divisor &&
      stg_ff[STEPS].lane[3].rem < stg_ff[STEPS].divisor)
      else $error("divider remainder out of range");

   // Every delivered duty is at most full scale
   a_duty_bound: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> out_ff.duty[0] <= mwsm_pkg::FULL_DUTY &&
                   out_ff.duty[1] <= mwsm_pkg::FULL_DUTY &&
                   out_ff.duty[2] <= mwsm_pkg::FULL_DUTY &&
                   out_ff.duty[3] <= mwsm_pkg::FULL_DUTY)
      else $error("duty above full scale");

endmodule

[tb/mecanum_wheel_speed_mixer_core_tb.sv]
// Testbench for mecanum_wheel_speed_mixer_core: drives velocity requests and
// register writes, predicts the four wheel duties/directions in a scoreboard.
// Depends on mwsm_pkg, mwsm_channels and the mixer core RTL.
module mecanum_wheel_speed_mixer_core_tb;

   localparam int NUM_PHASES     = 7;
   localparam int RAND_PER_PHASE = 195;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int DRAIN_CYCLES   = 30;     // pipeline latency plus margin
   localparam int IDLE_PCT       = 30;
   localparam int HOLD_AT        = 870;    // response count that starts the long stall
   localparam int HOLD_CYCLES    = 300;
   localparam int CALM_LO        = 410;    // responses taken with no stall
   localparam int CALM_HI        = 600;
   localparam logic [mwsm_pkg::CSR_IDX_W-1:0] CSR_FIRST_UNUSED = 8'd2;
   localparam logic [mwsm_pkg::CSR_IDX_W-1:0] CSR_LAST_UNUSED  = 8'hFF;

   typedef enum {FULL_RANGE, NEAR_ZERO, MODERATE} spread_type;
   typedef logic signed [mwsm_pkg::CMD_W-1:0] cmd_type;
   typedef logic [mwsm_pkg::CSR_DATA_W-1:0]   csr_data_type;

   // Expected wheel outputs, built from a private copy of the two registers
   class wheel_mix_scoreboard;
      csr_data_type          inv_radius;
      csr_data_type          half_base;
      mwsm_pkg::result_type  expected_wheels[$];
      int                    errors;
      int                    checked;

      function new();
         inv_radius = mwsm_pkg::RADIUS_RESET;
         half_base  = mwsm_pkg::BASE_RESET;
         errors     = 0;
         checked    = 0;
      endfunction

      function void write_reg(logic [mwsm_pkg::CSR_IDX_W-1:0] idx, csr_data_type data);
         if (idx == mwsm_pkg::CSR_INV_RADIUS) begin
            inv_radius = data;
         end else if (idx == mwsm_pkg::CSR_HALF_BASE) begin
            half_base = data;
         end
      endfunction

      function void note_request(cmd_type vx, cmd_type vy, cmd_type om);
         longint               rot;
         longint               lx;
         longint               ly;
         longint               speed[mwsm_pkg::WHEELS];
         longint unsigned      mag[mwsm_pkg::WHEELS];
         longint unsigned      peak;
         longint unsigned      duty;
         mwsm_pkg::result_type r;
         lx = longint'(vx);
         ly = longint'(vy);
         // rotation term in Q.12, round half up from Q.28
         rot = (longint'(om) * longint'(half_base) + 32768) >>> 16;
         speed[0] = (lx - ly - rot) * longint'(inv_radius);
         speed[1] = (lx + ly + rot) * longint'(inv_radius);
         speed[2] = (lx + ly - rot) * longint'(inv_radius);
         speed[3] = (lx - ly + rot) * longint'(inv_radius);
         peak = 0;
         for (int i = 0; i < mwsm_pkg::WHEELS; i++) begin
            mag[i] = (speed[i] < 0) ? longint'(-speed[i]) : speed[i];
            if (mag[i] > peak) peak = mag[i];
         end
         // scale down only when some wheel exceeds full speed
         for (int i = 0; i < mwsm_pkg::WHEELS; i++) begin
            if (peak > mwsm_pkg::ONE_Q20) begin
               duty = (mag[i] * mwsm_pkg::FULL_DUTY + (peak >> 1)) / peak;
            end else begin
               duty = (mag[i] + 16) >> 5;
            end
            r.duty[i]    = duty[mwsm_pkg::DUTY_W-1:0];
            r.forward[i] = (speed[i] >= 0);
         end
         expected_wheels.push_back(r);
      endfunction

      function void check_response(mwsm_pkg::result_type actual);
         mwsm_pkg::result_type exp_r;
         if (expected_wheels.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, actual);
            errors++;
            return;
         end
         exp_r = expected_wheels.pop_front();
         checked++;
         for (int i = 0; i < mwsm_pkg::WHEELS; i++) begin
            if (actual.duty[i] !== exp_r.duty[i]) begin
               $display("%0t: wheel%0d duty expected %0d actual %0d",
                        $time, i, exp_r.duty[i], actual.duty[i]);
               errors++;
            end
            if (actual.forward[i] !== exp_r.forward[i]) begin
               $display("%0t: wheel%0d forward expected %0d actual %0d",
                        $time, i, exp_r.forward[i], actual.forward[i]);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_wheels.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   sender_calm;
   int   cycle_count;

   mwsm_req_if req_if();
   mwsm_rsp_if rsp_if();
   mwsm_csr_if csr_if();

   wheel_mix_scoreboard sb = new();

   mecanum_wheel_speed_mixer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #10 clock = ~clock;

   // Present one velocity request and hold it until accepted
   task automatic offer(input cmd_type vx, input cmd_type vy, input cmd_type om);
      @(negedge clock);
      while (!sender_calm && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.speed_x   <= vx;
      req_if.speed_y   <= vy;
      req_if.turn_rate <= om;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(vx, vy, om);
   endtask

   // Stop offering and wait for every outstanding response
   task automatic pause_until_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mwsm_pkg::CSR_IDX_W-1:0] idx,
                            input csr_data_type data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   function automatic cmd_type rand_field(spread_type spread);
      case (spread)
         NEAR_ZERO: return cmd_type'($urandom_range(40) - 20);
         MODERATE:  return cmd_type'($urandom_range(8192) - 4096);
         default:   return cmd_type'($urandom_range(65535));
      endcase
   endfunction

   // Response side: random stalls, one calm stretch and one long hold-off
   initial begin
      bit hold_done;
      hold_done = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && sb.checked >= HOLD_AT) begin
            hold_done = 1;
            rsp_if.ready <= 1'b0;
            for (int held = 1; held < HOLD_CYCLES; held++) @(negedge clock);
         end else if (sb.checked >= CALM_LO && sb.checked < CALM_HI) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Response check at each accepting edge
   always @(posedge clock) begin
      mwsm_pkg::result_type actual;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         actual.duty[0]    = rsp_if.wheel0_duty;
         actual.duty[1]    = rsp_if.wheel1_duty;
         actual.duty[2]    = rsp_if.wheel2_duty;
         actual.duty[3]    = rsp_if.wheel3_duty;
         actual.forward[0] = rsp_if.wheel0_forward;
         actual.forward[1] = rsp_if.wheel1_forward;
         actual.forward[2] = rsp_if.wheel2_forward;
         actual.forward[3] = rsp_if.wheel3_forward;
         sb.check_response(actual);
      end
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Main sequence: phases of register settings, each with random requests, some with directed ones first
   initial begin
      int         pick;
      spread_type spread;
      cmd_type    fx;
      cmd_type    fy;
      cmd_type    fz;

      clock            = 1'b0;
      reset            = 1'b1;
      sender_calm      = 0;
      req_if.valid     = 1'b0;
      req_if.speed_x   = '0;
      req_if.speed_y   = '0;
      req_if.turn_rate = '0;
      csr_if.valid     = 1'b0;
      csr_if.index     = '0;
      csr_if.data      = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         sender_calm = (ph == 2);
         case (ph)
            0: begin
               // reset values; field extremes and each wheel's combination
               offer(0, 0, 0);
               offer(32767, 32767, 32767);
               offer(-32768, -32768, -32768);
               offer(32767, 0, 0);
               offer(-32768, 0, 0);
               offer(0, 32767, 0);
               offer(0, -32768, 0);
               offer(0, 0, 32767);
               offer(0, 0, -32768);
               offer(32767, -32768, 32767);
               offer(-32768, 32767, -32768);
               offer(1, 0, 0);
               offer(-1, 0, 0);
               offer(4096, 4096, 0);
            end
            1: begin
               write_reg(mwsm_pkg::CSR_INV_RADIUS, 16'd1);
               write_reg(mwsm_pkg::CSR_HALF_BASE, 16'd0);
               // tiny negative speeds round to zero duty but stay reverse
               offer(-1, 0, 0);
               offer(0, 1, 0);
               offer(15, -16, 0);
            end
            2: begin
               write_reg(mwsm_pkg::CSR_INV_RADIUS, 16'hFFFF);
               write_reg(mwsm_pkg::CSR_HALF_BASE, 16'hFFFF);
            end
            3: begin
               // zero radius, then writes to unused indexes that must be ignored
               write_reg(mwsm_pkg::CSR_INV_RADIUS, 16'd0);
               write_reg(mwsm_pkg::CSR_HALF_BASE, csr_data_type'($urandom_range(65535)));
               write_reg(CSR_FIRST_UNUSED, csr_data_type'($urandom_range(65535)));
               write_reg(CSR_LAST_UNUSED, csr_data_type'($urandom_range(65535)));
               offer(32767, -32768, 1000);
            end
            4: begin
               // unit gain: exactly full speed is not rescaled, one step over is
               write_reg(mwsm_pkg::CSR_INV_RADIUS, 16'd256);
               write_reg(mwsm_pkg::CSR_HALF_BASE, 16'd32768);
               offer(4096, 0, 0);
               offer(4097, 0, 0);
            end
            5: begin
               write_reg(mwsm_pkg::CSR_INV_RADIUS, csr_data_type'($urandom_range(65535, 1)));
               write_reg(mwsm_pkg::CSR_HALF_BASE, csr_data_type'($urandom_range(65535)));
            end
            default: begin
               write_reg(mwsm_pkg::CSR_INV_RADIUS, csr_data_type'($urandom_range(64, 1)));
               write_reg(mwsm_pkg::CSR_HALF_BASE, csr_data_type'($urandom_range(65535)));
            end
         endcase

         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            if (ph == 5 && n == 100) pause_until_drained();
            pick = $urandom_range(99);
            spread = (pick < 50) ? FULL_RANGE : (pick < 70) ? NEAR_ZERO : MODERATE;
            fx = rand_field(spread);
            fy = rand_field(spread);
            fz = rand_field(spread);
            offer(fx, fy, fz);
         end
         pause_until_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
